/* design/dtf_pkg.sv */
// Shared types, constants and the fraction weight table for the decimal text converter.
`default_nettype none

package dtf_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int MAX_FRAC_DIGITS = 8;

    localparam int CH_W     = 8;
    localparam int VALUE_W  = 64;
    localparam int MAG_W    = 63;
    localparam int COUNT_W  = 4;
    localparam int DIGIT_W  = 4;
    localparam int WEIGHT_W = FRAC_BITS + 1;
    localparam int PROD_W   = MAG_W + 5;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_LF    = 8'd10;
    localparam logic [CH_W-1:0] CH_VT    = 8'd11;
    localparam logic [CH_W-1:0] CH_FF    = 8'd12;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_POINT = 8'd46;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;

    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

    // Entry k-1 is 2^FRAC_BITS / 10^k rounded half up, k = 1..12; others are zero.
    localparam logic [WEIGHT_W-1:0] FRAC_WEIGHT [16] = '{
        WEIGHT_W'((ONE + 64'd5) / 64'd10),
        WEIGHT_W'((ONE + 64'd50) / 64'd100),
        WEIGHT_W'((ONE + 64'd500) / 64'd1000),
        WEIGHT_W'((ONE + 64'd5000) / 64'd10000),
        WEIGHT_W'((ONE + 64'd50000) / 64'd100000),
        WEIGHT_W'((ONE + 64'd500000) / 64'd1000000),
        WEIGHT_W'((ONE + 64'd5000000) / 64'd10000000),
        WEIGHT_W'((ONE + 64'd50000000) / 64'd100000000),
        WEIGHT_W'((ONE + 64'd500000000) / 64'd1000000000),
        WEIGHT_W'((ONE + 64'd5000000000) / 64'd10000000000),
        WEIGHT_W'((ONE + 64'd50000000000) / 64'd100000000000),
        WEIGHT_W'((ONE + 64'd500000000000) / 64'd1000000000000),
        WEIGHT_W'(0),
        WEIGHT_W'(0),
        WEIGHT_W'(0),
        WEIGHT_W'(0)
    };

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               saturated;
    } result_t;

endpackage

`default_nettype wire

/* design/dtf_parse.sv */
// Character parser and fixed-point accumulator, one character per cycle while beat is high.
`default_nettype none

module dtf_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  beat,
    input  wire logic [7:0]            ch,
    input  wire logic                  last,
    output logic                       result_valid,
    output dtf_pkg::result_t           result
);
    import dtf_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic                     negative_reg, negative_next;
    logic [MAG_W-1:0]         magnitude_reg, magnitude_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     overflowed_reg, overflowed_next;

    logic                     is_blank;
    logic                     is_digit;
    logic                     is_sign;
    logic [DIGIT_W-1:0]       digit;
    logic [PROD_W-1:0]        int_sum;
    logic                     int_over;
    logic [WEIGHT_W+DIGIT_W-1:0] addend;
    logic [VALUE_W-1:0]       frac_sum;
    logic                     frac_over;
    logic                     int_position;
    logic                     fin_negative;
    logic [MAG_W-1:0]         fin_magnitude;
    logic                     fin_overflowed;
    phase_t                   fin_phase;
    logic [COUNT_W-1:0]       fin_count;

    assign is_blank = (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_VT) ||
                      (ch == CH_FF) || (ch == CH_CR) || (ch == CH_SPACE);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign digit    = DIGIT_W'(ch - CH_ZERO);

    // Integer overflow is exactly 10 times magnitude plus digit << FRAC_BITS above the maximum.
    assign int_sum  = (PROD_W'(magnitude_reg) << 3) + (PROD_W'(magnitude_reg) << 1)
                      + (PROD_W'(digit) << FRAC_BITS);
    assign int_over = |int_sum[PROD_W-1:MAG_W];

    assign addend    = (WEIGHT_W+DIGIT_W)'(digit) * FRAC_WEIGHT[count_reg];
    assign frac_sum  = VALUE_W'(magnitude_reg) + VALUE_W'(addend);
    assign frac_over = frac_sum[VALUE_W-1];

    assign int_position = (phase_reg == PH_INT) ||
                          ((phase_reg == PH_SKIP) && !is_blank && !is_sign);

    always_comb
    begin
        fin_phase      = phase_reg;
        fin_negative   = negative_reg;
        fin_magnitude  = magnitude_reg;
        fin_count      = count_reg;
        fin_overflowed = overflowed_reg;

        if ((phase_reg == PH_SKIP) && is_sign)
        begin
            fin_negative = (ch == CH_MINUS);
            fin_phase    = PH_INT;
        end
        else if (int_position)
        begin
            priority if (is_digit)
            begin
                fin_phase = PH_INT;
                if (int_over)
                begin
                    fin_magnitude  = MAG_MAX;
                    fin_overflowed = 1'b1;
                end
                else
                begin
                    fin_magnitude = int_sum[MAG_W-1:0];
                end
            end
            else if (ch == CH_POINT)
            begin
                fin_phase = PH_FRAC;
            end
            else if (!is_blank)
            begin
                fin_phase = PH_DONE;
            end
            else
            begin
                fin_phase = PH_DONE;
            end
        end
        else if (phase_reg == PH_FRAC)
        begin
            if (!is_digit)
            begin
                fin_phase = PH_DONE;
            end
            else if (count_reg < COUNT_W'(MAX_FRAC_DIGITS))
            begin
                fin_count = count_reg + 1'b1;
                if (frac_over)
                begin
                    fin_magnitude  = MAG_MAX;
                    fin_overflowed = 1'b1;
                end
                else
                begin
                    fin_magnitude = frac_sum[MAG_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        magnitude_next  = magnitude_reg;
        count_next      = count_reg;
        overflowed_next = overflowed_reg;
        if (beat)
        begin
            if (last)
            begin
                phase_next      = PH_SKIP;
                negative_next   = 1'b0;
                magnitude_next  = '0;
                count_next      = '0;
                overflowed_next = 1'b0;
            end
            else
            begin
                phase_next      = fin_phase;
                negative_next   = fin_negative;
                magnitude_next  = fin_magnitude;
                count_next      = fin_count;
                overflowed_next = fin_overflowed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SKIP;
            negative_reg   <= 1'b0;
            magnitude_reg  <= '0;
            count_reg      <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            magnitude_reg  <= magnitude_next;
            count_reg      <= count_next;
            overflowed_reg <= overflowed_next;
        end
    end

    assign result_valid     = beat && last;
    assign result.value     = fin_negative ? (VALUE_W'(0) - VALUE_W'(fin_magnitude))
                                           : VALUE_W'(fin_magnitude);
    assign result.saturated = fin_overflowed;

endmodule

`default_nettype wire

/* design/dtf_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module dtf_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dtf_pkg::result_t  push_data,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dtf_pkg::result_t       out_data
);
    import dtf_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* design/decimal_text_to_fixed_point.sv */
// Top level of the decimal text to signed fixed-point converter.
//
// The slave stream carries one ASCII character per beat in s_axis_tdata, with
// s_axis_tlast set on the final character of a string. Leading white space is
// skipped, an optional sign, integer digits, a point and fraction digits are
// taken, and the first character that does not fit ends the number.
// The master stream carries one beat per string: the signed value with 24
// fraction bits in m_axis_tdata and the saturation flag in m_axis_tuser.
// A character is taken every cycle while s_axis_tready is high. The result of a
// string is formed combinationally from the parser state and the tlast beat
// and registered in the output register, or in the skid register if that is full.
// When the receiver stalls, one further result is held in a skid register and
// characters keep flowing; s_axis_tready drops only while that skid register
// is full, and rises again in the cycle after the receiver takes a beat.
// Reset returns the parser to skipping white space and empties both result
// registers.
`default_nettype none

module decimal_text_to_fixed_point (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] value
    output logic             m_axis_tuser    // [0] saturated
);
    import dtf_pkg::*;

    logic    beat;
    logic    result_valid;
    result_t result;
    result_t out_data;
    logic    space;

    assign s_axis_tready = space;
    assign beat          = s_axis_tvalid && space;

    dtf_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .ch           (s_axis_tdata),
        .last         (s_axis_tlast),
        .result_valid (result_valid),
        .result       (result)
    );

    dtf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.value;
    assign m_axis_tuser = out_data.saturated;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking stream testbench for the decimal text to fixed-point converter.
`timescale 1ns / 100ps

module testbench;

    import dtf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam longint unsigned MAG_LIMIT = 64'(MAG_MAX);

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    char_beat_t      pending_chars[$];
    result_t         expected_values[$];
    int              cycle_cnt;
    int              error_cnt;
    int              values_seen;
    int              hold_left;
    int              holds_done;
    bit              beat_taken;

    phase_t          cur_phase;
    logic            cur_negative;
    longint unsigned cur_mag;
    int              frac_count;
    logic            cur_overflow;

    decimal_text_to_fixed_point i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic bit pause_roll();
        if (cycle_cnt >= 300 && cycle_cnt < 700)
        begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 17;
    endfunction

    task automatic parse_char(input logic [7:0] ch, input logic last);
        longint unsigned scaled;
        longint unsigned pow_k;
        longint unsigned weight;
        logic            is_digit;
        logic [3:0]      digit;
        result_t         res;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        digit    = 4'(ch - CH_ZERO);
        if (cur_phase == PH_SKIP && (ch == CH_TAB || ch == CH_LF || ch == CH_VT ||
                                     ch == CH_FF || ch == CH_CR || ch == CH_SPACE))
        begin
            cur_phase = PH_SKIP;
        end
        else if (cur_phase == PH_SKIP && (ch == CH_PLUS || ch == CH_MINUS))
        begin
            cur_negative = (ch == CH_MINUS);
            cur_phase    = PH_INT;
        end
        else if (cur_phase == PH_SKIP || cur_phase == PH_INT)
        begin
            if (is_digit)
            begin
                cur_phase = PH_INT;
                scaled    = 64'(digit) << FRAC_BITS;
                if (cur_mag > (MAG_LIMIT - scaled) / 10)
                begin
                    cur_mag      = MAG_LIMIT;
                    cur_overflow = 1'b1;
                end
                else
                begin
                    cur_mag = cur_mag * 10 + scaled;
                end
            end
            else if (ch == CH_POINT)
            begin
                cur_phase = PH_FRAC;
            end
            else
            begin
                cur_phase = PH_DONE;
            end
        end
        else if (cur_phase == PH_FRAC)
        begin
            if (!is_digit)
            begin
                cur_phase = PH_DONE;
            end
            else if (frac_count < MAX_FRAC_DIGITS && frac_count < 12)
            begin
                pow_k = 1;
                repeat (frac_count + 1)
                begin
                    pow_k = pow_k * 10;
                end
                weight = ((64'd1 << FRAC_BITS) + pow_k / 2) / pow_k;
                if (64'(digit) * weight > MAG_LIMIT - cur_mag)
                begin
                    cur_mag      = MAG_LIMIT;
                    cur_overflow = 1'b1;
                end
                else
                begin
                    cur_mag = cur_mag + 64'(digit) * weight;
                end
                frac_count = (frac_count + 1) & 15;
            end
        end
        if (last)
        begin
            res.value     = cur_negative ? (64'd0 - cur_mag) : cur_mag;
            res.saturated = cur_overflow;
            expected_values.push_back(res);
            cur_phase    = PH_SKIP;
            cur_negative = 1'b0;
            cur_mag      = 0;
            frac_count   = 0;
            cur_overflow = 1'b0;
        end
    endtask

    // Input side: record each accepted beat and update the predicted value.
    always @(posedge clk)
    begin
        cycle_cnt  = cycle_cnt + 1;
        beat_taken = s_axis_tvalid && s_axis_tready;
        if (beat_taken)
        begin
            parse_char(s_axis_tdata, s_axis_tlast);
            void'(pending_chars.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!(s_axis_tvalid && !beat_taken))
        begin
            if (pending_chars.size() > 0 && !pause_roll())
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_chars[0].ch;
                s_axis_tlast  <= pending_chars[0].last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: the receiver stalls at random and twice holds off for a long stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (holds_done < 2 && values_seen >= 5 + 25 * holds_done)
        begin
            hold_left     = 80;
            holds_done    = holds_done + 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !pause_roll();
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            values_seen = values_seen + 1;
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected result, actual value %0d saturated %0b",
                         $time, $signed(m_axis_tdata), m_axis_tuser);
                error_cnt = error_cnt + 1;
            end
            else
            begin
                if (m_axis_tdata !== expected_values[0].value)
                begin
                    $display("%0t: value mismatch, expected %0d actual %0d", $time,
                             $signed(expected_values[0].value), $signed(m_axis_tdata));
                    error_cnt = error_cnt + 1;
                end
                if (m_axis_tuser !== expected_values[0].saturated)
                begin
                    $display("%0t: saturated mismatch, expected %0b actual %0b", $time,
                             expected_values[0].saturated, m_axis_tuser);
                    error_cnt = error_cnt + 1;
                end
                void'(expected_values.pop_front());
            end
        end
    end

    task automatic push_bytes(input logic [7:0] bytes[$]);
        char_beat_t b;
        foreach (bytes[i])
        begin
            b.ch   = bytes[i];
            b.last = (i == bytes.size() - 1);
            pending_chars.push_back(b);
        end
    endtask

    task automatic push_text(input string s);
        logic [7:0] bytes[$];
        for (int i = 0; i < s.len(); i++)
        begin
            bytes.push_back(s[i]);
        end
        push_bytes(bytes);
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_VT;
            3:       return CH_FF;
            4:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed numbers with random content; the rest is noise and broken text.
    task automatic add_random_string(output int added);
        logic [7:0] bytes[$];
        int         kind;
        int         sign_pick;
        int         int_len;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            repeat ($urandom_range(0, 2))
            begin
                bytes.push_back(random_blank());
            end
            sign_pick = $urandom_range(0, 2);
            if (sign_pick == 1)
            begin
                bytes.push_back(CH_PLUS);
            end
            else if (sign_pick == 2)
            begin
                bytes.push_back(CH_MINUS);
            end
            int_len = ($urandom_range(0, 9) < 2) ? $urandom_range(11, 18) : $urandom_range(0, 5);
            repeat (int_len)
            begin
                bytes.push_back(random_digit());
            end
            if ($urandom_range(0, 1))
            begin
                bytes.push_back(CH_POINT);
                repeat ($urandom_range(0, 11))
                begin
                    bytes.push_back(random_digit());
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (bytes.size() == 0)
            begin
                bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(1, 6))
            begin
                bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 4))
                    0:       bytes.push_back(CH_PLUS);
                    1:       bytes.push_back(CH_MINUS);
                    2:       bytes.push_back(CH_POINT);
                    3:       bytes.push_back(random_blank());
                    default: bytes.push_back(random_digit());
                endcase
            end
        end
        push_bytes(bytes);
        added = bytes.size();
    endtask

    initial
    begin
        int         random_chars;
        int         added;
        logic [7:0] single[$];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cycle_cnt     = 0;
        error_cnt     = 0;
        values_seen   = 0;
        hold_left     = 0;
        holds_done    = 0;
        beat_taken    = 1'b0;
        cur_phase     = PH_SKIP;
        cur_negative  = 1'b0;
        cur_mag       = 0;
        frac_count    = 0;
        cur_overflow  = 1'b0;

        single = '{8'h00};
        push_bytes(single);
        push_text("\t\n\v\f\r -");
        push_text(".");
        push_text("-.5");
        push_text("7+");
        push_text(".123456789");
        single = '{8'hFF};
        push_bytes(single);

        random_chars = 0;
        while (random_chars < 400)
        begin
            add_random_string(added);
            random_chars = random_chars + added;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_chars.size() != 0 || expected_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (error_cnt == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("FAIL");
        $finish;
    end

endmodule

/* decimal_text_to_fixed_point.f */
design/dtf_pkg.sv
design/dtf_parse.sv
design/dtf_out_buf.sv
design/decimal_text_to_fixed_point.sv
dv/testbench.sv
